// ===== rtl/core/ldsw_pkg.sv =====
// ----------------------------------------------------------------------------
// ldsw_pkg
// Shared types, constants and segment lookup for the decimal segment writer.
// ----------------------------------------------------------------------------
package ldsw_pkg;

  // Display geometry.
  localparam int POSITIONS         = 6;
  localparam int ROWS              = 4;
  localparam int DIGIT_COUNT_DEF   = 6;
  localparam int VALUE_W           = 32;
  localparam int ADDR_W            = 5;
  localparam int BYTE_W            = 8;
  localparam int POS_W             = $clog2(POSITIONS);
  localparam int ROW_W             = $clog2(ROWS);
  localparam int PAIR_W            = 2;

  // Digit code for an empty position.
  localparam logic [3:0] BLANK_CODE = 4'd10;

  // Reciprocal of ten: floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for any 32-bit v.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  // Last row and last pair of one update burst.
  localparam logic [ROW_W-1:0]  LAST_ROW  = 2'd3;
  localparam logic [PAIR_W-1:0] LAST_PAIR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;      // capture a new value and blank all positions
    logic              mul;       // form the quotient by ten
    logic              wr_digit;  // store the remainder digit, step to the quotient
    logic              emit;      // produce one register byte
    logic              last;      // this byte is the final one of the update
    logic [POS_W-1:0]  dig_pos;   // position that receives the digit
    logic [ROW_W-1:0]  row;       // LCD row of the byte being produced
    logic [PAIR_W-1:0] pair;      // digit pair of the byte being produced
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;   // value held is negative
    logic zero;  // value held is zero
  } dp_stat_t;

  // Segment pattern of a decimal digit, one byte per row with the top row high.
  function automatic logic [31:0] seg_pattern(input logic [3:0] code);
    logic [31:0] pat;
    case (code)
      4'd0:    pat = 32'h0105_0501;
      4'd1:    pat = 32'h0801_0100;
      4'd2:    pat = 32'h0101_0E01;
      4'd3:    pat = 32'h0101_0901;
      4'd4:    pat = 32'h0005_0B00;
      4'd5:    pat = 32'h0104_0B01;
      4'd6:    pat = 32'h0104_0F01;
      4'd7:    pat = 32'h0900_0004;
      4'd8:    pat = 32'h0105_0F01;
      4'd9:    pat = 32'h0105_0B01;
      default: pat = 32'h0000_0000;
    endcase
    return pat;
  endfunction

  // Four-bit segment nibble of a digit code on one row.
  function automatic logic [3:0] row_nibble(input logic [3:0] code,
                                            input logic [ROW_W-1:0] row);
    logic [31:0] pat;
    logic [3:0]  nib;
    pat = seg_pattern(code);
    case (row)
      2'd0:    nib = pat[27:24];
      2'd1:    nib = pat[19:16];
      2'd2:    nib = pat[11:8];
      2'd3:    nib = pat[3:0];
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

// ===== rtl/core/ldsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldsw_ctrl
// Sequencer: digit extraction loop followed by the twelve-byte output burst.
// ----------------------------------------------------------------------------
module ldsw_ctrl import ldsw_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUB  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              first_r, first_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PAIR_W-1:0] pair_r, pair_nxt;
  logic              last_byte;

  assign busy      = (state_r != ST_IDLE);
  assign last_byte = (row_r == LAST_ROW) && (pair_r == LAST_PAIR);

  // Next-state and counter logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    row_nxt   = row_r;
    pair_nxt  = pair_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
          cnt_nxt   = CNT_W'(DIGIT_COUNT);
          first_nxt = 1'b1;
          row_nxt   = '0;
          pair_nxt  = '0;
        end
      end
      ST_MUL: begin
        // A zero value still gets one digit on the first pass.
        if (stat.neg || (stat.zero && !first_r) || (cnt_r == '0)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SUB;
        end
      end
      ST_SUB: begin
        state_nxt = ST_MUL;
        cnt_nxt   = cnt_r - CNT_W'(1);
        first_nxt = 1'b0;
      end
      ST_EMIT: begin
        if (pair_r == LAST_PAIR) begin
          pair_nxt = '0;
          row_nxt  = row_r + ROW_W'(1);
        end else begin
          pair_nxt = pair_r + PAIR_W'(1);
        end
        if (last_byte) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.mul      = (state_r == ST_MUL);
    cmd.wr_digit = (state_r == ST_SUB);
    cmd.emit     = (state_r == ST_EMIT);
    cmd.last     = (state_r == ST_EMIT) && last_byte;
    cmd.dig_pos  = POS_W'(cnt_r - CNT_W'(1));
    cmd.row      = row_r;
    cmd.pair     = pair_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      first_r <= 1'b0;
      row_r   <= '0;
      pair_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      row_r   <= row_nxt;
      pair_r  <= pair_nxt;
    end
  end

endmodule

// ===== rtl/core/ldsw_datapath.sv =====
// ----------------------------------------------------------------------------
// ldsw_datapath
// Divide-by-ten digit extraction, digit code storage and output byte register.
// ----------------------------------------------------------------------------
module ldsw_datapath import ldsw_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VALUE_W-1:0]  in_value,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_reg_address,
  output logic [BYTE_W-1:0]   out_reg_byte,
  output logic                out_last_write
);

  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [VALUE_W-1:0]   quo_r, quo_nxt;
  logic [2*VALUE_W-1:0] prod;
  logic [3:0]           ten_q_lo;
  logic [3:0]           digit;
  logic [3:0]           codes_r   [POSITIONS];
  logic [3:0]           codes_nxt [POSITIONS];
  logic [ADDR_W-1:0]    addr_calc;
  logic [BYTE_W-1:0]    byte_calc;
  logic                 valid_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [BYTE_W-1:0]    byte_r;
  logic                 last_r;

  assign stat.neg  = val_r[VALUE_W-1];
  assign stat.zero = (val_r == '0);

  // Quotient by ten through the reciprocal multiply.
  assign prod = {{VALUE_W{1'b0}}, val_r} * {{VALUE_W{1'b0}}, RECIP_TEN};

  // The remainder is below ten, so four low bits of v - 10q are enough.
  assign ten_q_lo = {quo_r[0], 3'b000} + {quo_r[2:0], 1'b0};
  assign digit    = val_r[3:0] - ten_q_lo;

  // Value and quotient registers.
  always_comb begin
    val_nxt = val_r;
    quo_nxt = quo_r;
    if (cmd.load) begin
      val_nxt = in_value;
    end else if (cmd.wr_digit) begin
      val_nxt = quo_r;
    end
    if (cmd.mul) begin
      quo_nxt = VALUE_W'(prod >> RECIP_SHIFT);
    end
  end

  // Digit codes: blanked on load, written per digit, rotated by one pair per byte.
  always_comb begin
    for (int i = 0; i < POSITIONS; i++) begin
      codes_nxt[i] = codes_r[i];
      if (cmd.load) begin
        codes_nxt[i] = BLANK_CODE;
      end else if (cmd.wr_digit && (cmd.dig_pos == POS_W'(i))) begin
        codes_nxt[i] = digit;
      end else if (cmd.emit) begin
        codes_nxt[i] = codes_r[(i + 2) % POSITIONS];
      end
    end
  end

  // Output byte: register row*5 + pair, even position in the low nibble.
  assign addr_calc = {1'b0, cmd.row, 2'b00} + {3'b000, cmd.row} + {3'b000, cmd.pair};
  assign byte_calc = {row_nibble(codes_r[1], cmd.row), row_nibble(codes_r[0], cmd.row)};

  // Payload registers.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    for (int i = 0; i < POSITIONS; i++) begin
      codes_r[i] <= codes_nxt[i];
    end
    if (cmd.emit) begin
      addr_r <= addr_calc;
      byte_r <= byte_calc;
    end
  end

  // Output strobe and last-byte flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      last_r  <= cmd.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_reg_address = addr_r;
  assign out_reg_byte    = byte_r;
  assign out_last_write  = last_r;

endmodule

// ===== rtl/core/lcd_decimal_segment_writer.sv =====
// ----------------------------------------------------------------------------
// lcd_decimal_segment_writer
// Converts a signed number to six right-aligned decimal digits and emits the
// twelve LCD data register bytes that show it.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low. The block then peels off
// one decimal digit per pass (a reciprocal multiply by one tenth, then a
// remainder step), for at most DIGIT_COUNT digits; a negative value skips
// this and a zero value takes one digit. After that it presents twelve bytes
// back to back, each marked by out_valid, in register order
// 0,1,2,5,6,7,10,11,12,15,16,17, with out_last_write on the twelfth. busy
// drops as the final byte is loaded into the output register, so the next
// value can be taken while it is shown. Results cannot be stalled: each byte
// is valid for exactly one cycle and must be captured then.
// ----------------------------------------------------------------------------
module lcd_decimal_segment_writer import ldsw_pkg::*; #(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_reg_address,
  output logic [BYTE_W-1:0]   out_reg_byte,
  output logic                out_last_write
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  ldsw_ctrl #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Arithmetic and output registers.
  ldsw_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_reg_address (out_reg_address),
    .out_reg_byte    (out_reg_byte),
    .out_last_write  (out_last_write)
  );

endmodule

// ===== rtl/core/ldsw_checker.sv =====
// ----------------------------------------------------------------------------
// ldsw_checker
// Port-level checks on the update burst of the decimal segment writer.
// ----------------------------------------------------------------------------
module ldsw_checker import ldsw_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [ADDR_W-1:0]  out_reg_address,
  input logic               out_last_write
);

  // An accepted transaction keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // The final byte is a strobed write to the last data register.
  a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_write |-> (out_valid && (out_reg_address == 5'd17)))
    else $error("last write flag on a wrong or unstrobed byte");

  // Bytes of one update come back to back until the final one.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_write) |=> out_valid)
    else $error("gap inside an update burst");

  // Only LCD data register addresses are written.
  a_addr_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reg_address == 5'd0  || out_reg_address == 5'd1  ||
                   out_reg_address == 5'd2  || out_reg_address == 5'd5  ||
                   out_reg_address == 5'd6  || out_reg_address == 5'd7  ||
                   out_reg_address == 5'd10 || out_reg_address == 5'd11 ||
                   out_reg_address == 5'd12 || out_reg_address == 5'd15 ||
                   out_reg_address == 5'd16 || out_reg_address == 5'd17))
    else $error("write to an address outside the data registers");

endmodule

bind lcd_decimal_segment_writer ldsw_checker u_ldsw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_reg_address (out_reg_address),
  .out_last_write  (out_last_write)
);
